// File: rtl/cfsi_pkg.sv
// Shared constants, types and coding functions for the chirp symbol FEC interleaver.
`default_nettype none
package cfsi_pkg;

  localparam int DEF_MAX_SF = 12;
  localparam int SF_MIN     = 6;
  localparam int NCOL       = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SF  = 2'd0;
  localparam logic [1:0] CFG_CR  = 2'd1;
  localparam logic [1:0] CFG_LDR = 2'd2;

  // coding rates
  localparam logic [2:0] RATE_1 = 3'd1;
  localparam logic [2:0] RATE_2 = 3'd2;
  localparam logic [2:0] RATE_3 = 3'd3;
  localparam logic [2:0] RATE_4 = 3'd4;

  // parity masks
  localparam logic [3:0] MASK_P1 = 4'h0D;
  localparam logic [3:0] MASK_P2 = 4'h0B;
  localparam logic [3:0] MASK_P3 = 4'h07;
  localparam logic [3:0] MASK_P4 = 4'h0F;
  localparam logic [3:0] MASK_P5 = 4'h0E;

  typedef struct packed {
    logic [3:0] sf;    // saturated spreading factor
    logic [3:0] ppm;   // bits per symbol used by this block
    logic       quad;  // reduced-rate mapping: s*4+1
  } map_ctl_t;

  function automatic logic par4(input logic [3:0] d, input logic [3:0] mask);
    return ^(d & mask);
  endfunction

  function automatic logic [7:0] make_codeword(input logic [3:0] d, input logic [2:0] rate);
    logic p1, p2, p3, p4, p5;
    logic [7:0] cw;
    p1 = par4(d, MASK_P1);
    p2 = par4(d, MASK_P2);
    p3 = par4(d, MASK_P3);
    p4 = par4(d, MASK_P4);
    p5 = par4(d, MASK_P5);
    unique case (rate)
      RATE_1:  cw = {3'b000, p4, d};
      RATE_2:  cw = {2'b00, p5, p3, d};
      RATE_3:  cw = {1'b0, p2, p5, p3, d};
      default: cw = {p1, p2, p5, p3, d};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cfsi_symbol_map.sv
// Column to symbol mapping: diagonal rotation, inverse Gray decode, symbol offset.
`default_nettype none
module cfsi_symbol_map #(
  parameter int MAX_SF = cfsi_pkg::DEF_MAX_SF
) (
  input  wire logic [MAX_SF-1:0] col,
  input  wire logic [2:0]        idx,
  input  wire cfsi_pkg::map_ctl_t ctl,
  output logic      [MAX_SF-1:0] sym
);
  import cfsi_pkg::*;

  localparam int W2 = 2 * MAX_SF;

  logic [MAX_SF:0]   ppm_mask;
  logic [MAX_SF:0]   sf_mask;
  logic [MAX_SF-1:0] v;
  logic [3:0]        im;
  logic [3:0]        rot;
  logic [W2-1:0]     shl;
  logic [W2-1:0]     shr;
  logic [MAX_SF-1:0] rv;
  logic [MAX_SF-1:0] gd;
  logic [MAX_SF+1:0] mapped;

  always_comb begin
    ppm_mask = ({{MAX_SF{1'b0}}, 1'b1} << ctl.ppm) - {{MAX_SF{1'b0}}, 1'b1};
    sf_mask  = ({{MAX_SF{1'b0}}, 1'b1} << ctl.sf) - {{MAX_SF{1'b0}}, 1'b1};
    v        = col & ppm_mask[MAX_SF-1:0];
    // index mod ppm; ppm is at least 4 and idx below 8
    im  = ({1'b0, idx} >= ctl.ppm) ? ({1'b0, idx} - ctl.ppm) : {1'b0, idx};
    rot = (im == 4'd0) ? 4'd0 : (ctl.ppm - im);
    shl = {{MAX_SF{1'b0}}, v} << rot;
    shr = {{MAX_SF{1'b0}}, v} >> (ctl.ppm - rot);
    rv  = (shl[MAX_SF-1:0] | shr[MAX_SF-1:0]) & ppm_mask[MAX_SF-1:0];
    // inverse Gray: each bit is the XOR of itself and all bits above
    for (int k = 0; k < MAX_SF; k++) begin
      gd[k] = ^(rv >> k);
    end
    if (ctl.quad) begin
      mapped = {gd, 2'b01};
    end else begin
      mapped = {2'b00, gd} + {{(MAX_SF+1){1'b0}}, 1'b1};
    end
    sym = mapped[MAX_SF-1:0] & sf_mask[MAX_SF-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/chirp_symbol_fec_interleaver.sv
// Top level: nibble encoder, column interleaver, block emit buffer and output register.
// Path: the nibble that closes a block goes into the emit buffer; its symbols then leave through
// the output register, one per cycle while out_stall is low (8 for a first block, else cr+4).
// Throughput: one nibble per cycle, set by the single column update per cycle; input
// stalls only when a nibble may close a block while the emit buffer still holds the last.
// Reset (rst, synchronous): config to SF 7 / CR 1 / LDR 0, columns and counters cleared.
`default_nettype none
module chirp_symbol_fec_interleaver #(
  parameter int MAX_SF = cfsi_pkg::DEF_MAX_SF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [3:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        nibble,
  input  wire logic              packet_start,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [MAX_SF-1:0] symbol,
  output logic                   last_of_block
);
  import cfsi_pkg::*;

  // configuration
  logic [3:0] sf_reg;
  logic [2:0] cr_reg;
  logic       ldr_reg;
  logic [3:0] sf_sat;
  logic [2:0] rate_sat;

  // interleaver state
  logic [MAX_SF-1:0] col [NCOL];
  logic [MAX_SF-1:0] col_next [NCOL];
  logic [3:0]        wib;
  logic              fbd;

  // emit buffer
  logic [MAX_SF-1:0] ecol [NCOL];
  logic [3:0]        ebpw;
  map_ctl_t          ectl;
  logic [2:0]        eidx;
  logic              ebusy;

  logic       first_st;
  logic [3:0] ppm_st;
  logic       first_eff;
  logic [3:0] ppm_eff;
  logic [3:0] bpw_eff;
  logic [3:0] wib_eff;
  logic [3:0] wib_inc;
  logic [7:0] cw;
  logic       accept;
  logic       blk_done;
  logic       out_load;
  logic [MAX_SF-1:0] map_sym;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (sf_reg < 4'(SF_MIN)) begin
      sf_sat = 4'(SF_MIN);
    end else if (sf_reg > 4'(MAX_SF)) begin
      sf_sat = 4'(MAX_SF);
    end else begin
      sf_sat = sf_reg;
    end
    priority if (cr_reg < RATE_1) begin
      rate_sat = RATE_1;
    end else if (cr_reg > RATE_4) begin
      rate_sat = RATE_4;
    end else begin
      rate_sat = cr_reg;
    end
  end

  always_comb begin
    first_st  = !fbd;
    ppm_st    = (first_st || ldr_reg) ? (sf_sat - 4'd2) : sf_sat;
    // a new packet never closes a block on its first word, so state values suffice
    in_stall  = ebusy && ((wib + 4'd1) >= ppm_st);
    first_eff = packet_start || !fbd;
    ppm_eff   = (first_eff || ldr_reg) ? (sf_sat - 4'd2) : sf_sat;
    bpw_eff   = first_eff ? 4'd8 : ({1'b0, rate_sat} + 4'd4);
    wib_eff   = packet_start ? 4'd0 : wib;
    wib_inc   = wib_eff + 4'd1;
    cw        = make_codeword(nibble, first_eff ? RATE_4 : rate_sat);
    accept    = in_valid && !in_stall;
    blk_done  = wib_inc >= ppm_eff;
    for (int x = 0; x < NCOL; x++) begin
      for (int j = 0; j < MAX_SF; j++) begin
        col_next[x][j] = (col[x][j] && !packet_start) ||
                         (cw[x] && (4'(x) < bpw_eff) && (wib_eff == 4'(j)));
      end
    end
    out_load = ebusy && (!out_valid || !out_stall);
  end

  cfsi_symbol_map #(
    .MAX_SF(MAX_SF)
  ) u_map (
    .col(ecol[eidx]),
    .idx(eidx),
    .ctl(ectl),
    .sym(map_sym)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_reg    <= 4'd7;
      cr_reg    <= RATE_1;
      ldr_reg   <= 1'b0;
      wib       <= 4'd0;
      fbd       <= 1'b0;
      ebusy     <= 1'b0;
      eidx      <= 3'd0;
      out_valid <= 1'b0;
      for (int x = 0; x < NCOL; x++) begin
        col[x] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SF:  sf_reg  <= cfg_data;
          CFG_CR:  cr_reg  <= cfg_data[2:0];
          CFG_LDR: ldr_reg <= cfg_data[0];
          default: ;
        endcase
      end

      if (accept) begin
        if (blk_done) begin
          for (int x = 0; x < NCOL; x++) begin
            col[x]  <= '0;
            ecol[x] <= col_next[x];
          end
          wib       <= 4'd0;
          fbd       <= 1'b1;
          ebusy     <= 1'b1;
          eidx      <= 3'd0;
          ebpw      <= bpw_eff;
          ectl.sf   <= sf_sat;
          ectl.ppm  <= ppm_eff;
          ectl.quad <= first_eff || ldr_reg;
        end else begin
          for (int x = 0; x < NCOL; x++) begin
            col[x] <= col_next[x];
          end
          wib <= wib_inc;
          fbd <= fbd && !packet_start;
        end
      end

      if (out_load) begin
        out_valid     <= 1'b1;
        symbol        <= map_sym;
        last_of_block <= (({1'b0, eidx} + 4'd1) == ebpw);
        if (({1'b0, eidx} + 4'd1) == ebpw) begin
          ebusy <= 1'b0;
        end else begin
          eidx <= eidx + 3'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a block never closes while the previous one is still being emitted
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (accept && blk_done) |-> !ebusy)
    else $error("block closed while emit buffer busy");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ebusy |-> (({1'b0, eidx} + 4'd1) <= ebpw))
    else $error("emit index past block width");

  a_wib_bound: assert property (@(posedge clk) disable iff (rst)
    wib < 4'(MAX_SF))
    else $error("word count past block size");

  a_busy_src: assert property (@(posedge clk) disable iff (rst)
    $rose(ebusy) |-> $past(accept && blk_done))
    else $error("emit started without a closed block");
`endif

endmodule
`default_nettype wire

// File: dv/interleave_checker.sv
// Watches the interleaver channels, predicts each symbol word and compares it with the output.
module interleave_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [3:0]                    cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [3:0]                    nibble,
  input  wire logic                          packet_start,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [cfsi_pkg::DEF_MAX_SF-1:0] symbol,
  input  wire logic                          last_of_block,
  output int                                 errors,
  output int                                 pending
);
  import cfsi_pkg::*;

  typedef struct packed {
    logic [11:0] value;
    logic        last;
  } sym_word_t;

  sym_word_t   due_symbols[$];

  logic [3:0]  reg_sf;
  logic [2:0]  reg_cr;
  logic        reg_ldr;
  logic [11:0] columns [NCOL];
  int          words_held;
  logic        first_done;

  task automatic report_mismatch(input string msg);
    // keep the log short if the block is badly off
    if (errors < 50) $display("%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] codeword(input logic [3:0] d, input int rate);
    logic q1, q2, q3, q4, q5;
    q1 = ^(d & MASK_P1);
    q2 = ^(d & MASK_P2);
    q3 = ^(d & MASK_P3);
    q4 = ^(d & MASK_P4);
    q5 = ^(d & MASK_P5);
    if (rate == RATE_1) return {3'b000, q4, d};
    if (rate == RATE_2) return {2'b00, q5, q3, d};
    if (rate == RATE_3) return {1'b0, q2, q5, q3, d};
    return {q1, q2, q5, q3, d};
  endfunction

  function automatic int rotl(input int v, input int r, input int n);
    int mask;
    mask = (1 << n) - 1;
    v = v & mask;
    if (r == 0) return v;
    return ((v << r) | (v >> (n - r))) & mask;
  endfunction

  // undo Gray: each bit becomes the XOR of itself and all bits above it
  function automatic int gray_undo(input int s);
    for (int k = 10; k >= 0; k--) s[k] = s[k] ^ s[k+1];
    return s;
  endfunction

  function automatic void clear_block();
    for (int k = 0; k < NCOL; k++) columns[k] = '0;
    words_held = 0;
  endfunction

  task automatic take_nibble(input logic [3:0] nib, input logic start);
    int        sf, rate, ppm, bpw, rot, s, sym;
    logic      first;
    logic [7:0] cw;
    sym_word_t w;
    sf = int'(reg_sf);
    if (sf < SF_MIN) sf = SF_MIN;
    if (sf > DEF_MAX_SF) sf = DEF_MAX_SF;
    rate = int'(reg_cr);
    if (rate < RATE_1) rate = RATE_1;
    if (rate > RATE_4) rate = RATE_4;
    if (start) begin
      clear_block();
      first_done = 1'b0;
    end
    first = !first_done;
    bpw   = first ? 8 : rate + 4;
    ppm   = first ? sf - 2 : sf - 2 * int'(reg_ldr);
    cw    = codeword(nib, first ? int'(RATE_4) : rate);
    if (words_held < 12) begin
      for (int x = 0; x < bpw; x++) columns[x][words_held] = columns[x][words_held] | cw[x];
    end
    words_held = (words_held + 1) & 15;
    if (words_held < ppm) return;
    for (int i = 0; i < bpw; i++) begin
      rot = (10 * ppm - i) % ppm;
      s   = gray_undo(rotl(int'(columns[i]), rot, ppm));
      sym = (first || reg_ldr) ? s * 4 + 1 : s + 1;
      sym = sym & ((1 << sf) - 1);
      w.value = sym[11:0];
      w.last  = (i + 1 == bpw);
      due_symbols = {due_symbols, w};
    end
    clear_block();
    first_done = 1'b1;
  endtask

  task automatic check_output();
    sym_word_t w;
    if (due_symbols.size() == 0) begin
      report_mismatch($sformatf("symbol word %0d with nothing expected", symbol));
      return;
    end
    w = due_symbols.pop_front();
    if (symbol != w.value)
      report_mismatch($sformatf("symbol: got %0d want %0d", symbol, w.value));
    if (last_of_block != w.last)
      report_mismatch($sformatf("last_of_block: got %0b want %0b", last_of_block, w.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reg_sf  = 4'd7;
      reg_cr  = RATE_1;
      reg_ldr = 1'b0;
      clear_block();
      first_done = 1'b0;
      due_symbols.delete();
    end else begin
      if (out_valid && !out_stall) check_output();
      // a word taken at the same edge as a register write still sees the old settings
      if (in_valid && !in_stall) take_nibble(nibble, packet_start);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SF:  reg_sf  = cfg_data;
          CFG_CR:  reg_cr  = cfg_data[2:0];
          CFG_LDR: reg_ldr = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= due_symbols.size();
  end

endmodule

// File: dv/tb_top.sv
// Stimulus and verdict for the chirp symbol FEC interleaver, checked by interleave_checker.
module tb_top;
  import cfsi_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 16;
  localparam int         LONG_HOLD   = 400;
  localparam int         PHASES      = 9;
  localparam int         PHASE_ITEMS = 24;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index    = CFG_SF;
  logic [3:0]            cfg_data     = 4'd0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [3:0]            nibble       = 4'd0;
  logic                  packet_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [DEF_MAX_SF-1:0] symbol;
  logic                  last_of_block;

  int errors;
  int pending;
  int cycle_count;
  int cur_sf;
  int cur_ldr;
  int phase_sent;
  bit no_gaps;

  // raw register values per phase; some are out of range on purpose
  logic [3:0] sf_list  [PHASES] = '{4'd6, 4'd12, 4'd12, 4'd6, 4'd0, 4'd15, 4'd9, 4'd13, 4'd8};
  logic [3:0] cr_list  [PHASES] = '{4'd1, 4'd4, 4'd4, 4'd2, 4'd0, 4'd7, 4'd10, 4'd13, 4'd3};
  logic [3:0] ldr_list [PHASES] = '{4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd14, 4'd15, 4'd1};

  always #5 clk = ~clk;

  chirp_symbol_fec_interleaver DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .nibble(nibble), .packet_start(packet_start),
    .out_valid(out_valid), .out_stall(out_stall), .symbol(symbol),
    .last_of_block(last_of_block)
  );

  interleave_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .nibble(nibble), .packet_start(packet_start),
    .out_valid(out_valid), .out_stall(out_stall), .symbol(symbol),
    .last_of_block(last_of_block), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold so the block backs up into its input
  initial begin
    int stall_left, free_left, taken;
    bit held;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!held && taken >= 40 && in_valid) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b0;
        free_left  = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 12);
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_nibble(input logic [3:0] n, input logic ps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    nibble       <= n;
    packet_start <= ps;
    do @(posedge clk); while (in_stall);
    phase_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [3:0] sf, input logic [3:0] cr, input logic [3:0] ldr);
    write_reg(CFG_SF, sf);
    write_reg(CFG_CR, cr);
    write_reg(CFG_LDR, ldr);
    cfg_valid <= 1'b0;
    cur_sf  = (sf < SF_MIN) ? SF_MIN : (sf > DEF_MAX_SF) ? DEF_MAX_SF : int'(sf);
    cur_ldr = int'(ldr[0]);
  endtask

  // wait for every expected word, then let a partial block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly whole blocks; now and then a short broken packet
  task automatic send_packet();
    int first_len, later_len, n;
    first_len = cur_sf - 2;
    later_len = cur_sf - 2 * cur_ldr;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 6);
    end else begin
      n = first_len + later_len * $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, later_len - 1);
    end
    for (int k = 0; k < n; k++) send_nibble(4'($urandom_range(0, 15)), k == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: SF 7, CR 1, no LDR -> first block of 5 words, then blocks of 7
    send_nibble(4'h0, 1'b1);
    send_nibble(4'hF, 1'b0);
    send_nibble(4'h5, 1'b0);
    send_nibble(4'hA, 1'b0);
    send_nibble(4'h3, 1'b0);
    send_nibble(4'h1, 1'b0);
    send_nibble(4'h2, 1'b0);
    send_nibble(4'h4, 1'b0);
    send_nibble(4'h8, 1'b0);
    send_nibble(4'h6, 1'b0);
    send_nibble(4'h9, 1'b0);
    send_nibble(4'hC, 1'b0);
    // packet restart drops a partial block
    send_nibble(4'h7, 1'b1);
    send_nibble(4'hE, 1'b0);
    send_nibble(4'hB, 1'b0);
    send_nibble(4'hD, 1'b1);
    send_nibble(4'h0, 1'b0);
    send_nibble(4'hF, 1'b0);
    // three words stay in the block across the next settings change
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) write_reg(CFG_UNUSED, 4'h5);
      apply_setting(sf_list[p], cr_list[p], ldr_list[p]);
      no_gaps    = ($urandom_range(0, 3) == 0);
      phase_sent = 0;
      // continue whatever block was left open under the new settings
      repeat ($urandom_range(1, 3)) send_nibble(4'($urandom_range(0, 15)), 1'b0);
      while (phase_sent < PHASE_ITEMS) send_packet();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cfsi_pkg.sv
rtl/cfsi_symbol_map.sv
rtl/chirp_symbol_fec_interleaver.sv
dv/interleave_checker.sv
dv/tb_top.sv
